// ===== rtl/b64u_pkg.sv =====
// Shared types, phase codes and the base64url alphabet for the stream encoder.
package b64u_pkg;

    // Position of the next byte inside its three-byte group.
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } byte_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } char_item_t;

    // One or two characters produced by one input byte.
    typedef struct packed {
        char_item_t first;
        char_item_t second;
        logic       two;
    } char_pair_t;

    // Sextet to ASCII: A-Z, a-z, 0-9, '-', '_'.
    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] sextet);
        logic [6:0] code;
        if (sextet < 6'd26) begin
            code = 7'd65 + {1'b0, sextet};
        end else if (sextet < 6'd52) begin
            code = 7'd71 + {1'b0, sextet};    // 'a' - 26
        end else if (sextet < 6'd62) begin
            code = {1'b0, sextet} - 7'd4;     // '0' - 52
        end else if (sextet == 6'd62) begin
            code = 7'd45;                     // '-'
        end else begin
            code = 7'd95;                     // '_'
        end
        return code;
    endfunction

endpackage

// ===== rtl/b64u_pair_q.sv =====
// Two-entry queue of character pairs, drained one character per item.
module b64u_pair_q
    import b64u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_pair_t pair,
    output logic       full,
    output logic       char_valid,
    input  logic       char_stall,
    output char_item_t char_item
);

    char_pair_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]       count_reg, count_next;
    logic                      sub_reg, sub_next;
    logic                      take;
    logic                      pop;
    char_pair_t                head;

    assign head       = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign char_valid = (count_reg != '0);
    assign char_item  = sub_reg ? head.second : head.first;
    assign take       = char_valid && !char_stall;
    assign pop        = take && (!head.two || sub_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        sub_next    = sub_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            sub_next    = 1'b0;
        end else if (take) begin
            sub_next    = 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= pair;
        end
    end

    // never more entries than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("pair queue over capacity");

    // second-char select only while a pair is held
    a_sub_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> char_valid)
        else $error("second char selected with empty queue");

    // last entry drained with no refill leaves the output idle
    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QUEUE_CW'(1) && pop && !push) |=> !char_valid)
        else $error("output valid after final entry drained");

endmodule

// ===== rtl/base64url_stream_encoder_top.sv =====
// Top level of the unpadded URL-safe base64 stream encoder.
//
// Usage:
//   byte channel: one message byte per item (data_byte) with final_byte set on
//   the last byte of a message. Accepted when byte_valid is high and
//   byte_stall is low.
//   char channel: one ASCII character per item (char_code), last_char set on
//   the final character of the message. Accepted when char_valid is high and
//   char_stall is low.
// Output: the pair for an accepted byte is registered into the queue and shows
//   on the char channel once the pairs ahead of it have drained. A byte yields
//   one character, or two on the third byte of a group and on the final byte.
// Throughput: one byte per cycle into a two-pair queue while byte_stall is low;
//   the char side drains one character per cycle while char_stall is low, so a
//   long run of full groups is set by the single character output port.
// Stall: byte_stall rises only when both queue slots hold pairs; it does not
//   follow char_stall in the same cycle.
// Reset: rst_n clears the group phase, the leftover bits and the queue.
module base64url_stream_encoder_top
    import b64u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       char_valid,
    input  logic       char_stall,
    output char_item_t char_item
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic       accept;
    logic       full;
    logic [5:0] sextet0, sextet1;
    logic       two;
    char_pair_t pair;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    // Split the byte against the group phase.
    always_comb
    begin
        case (phase_reg)
            PHASE_SECOND:
            begin
                sextet0    = {left_reg[1:0], byte_item.data_byte[7:4]};
                sextet1    = {byte_item.data_byte[3:0], 2'b00};
                two        = byte_item.final_byte;
                left_next  = byte_item.data_byte[3:0];
                phase_next = PHASE_THIRD;
            end
            PHASE_THIRD:
            begin
                sextet0    = {left_reg, byte_item.data_byte[7:6]};
                sextet1    = byte_item.data_byte[5:0];
                two        = 1'b1;
                left_next  = 4'd0;
                phase_next = PHASE_FIRST;
            end
            default:
            begin
                // first byte; the unused phase code falls here too
                sextet0    = byte_item.data_byte[7:2];
                sextet1    = {byte_item.data_byte[1:0], 4'b0000};
                two        = byte_item.final_byte;
                left_next  = {2'b00, byte_item.data_byte[1:0]};
                phase_next = PHASE_SECOND;
            end
        endcase
        if (byte_item.final_byte) begin
            // message ends: flush and restart the group
            left_next  = 4'd0;
            phase_next = PHASE_FIRST;
        end
    end

    always_comb
    begin
        pair.first.char_code  = sextet_to_ascii(sextet0);
        pair.first.last_char  = 1'b0;
        pair.second.char_code = sextet_to_ascii(sextet1);
        pair.second.last_char = byte_item.final_byte;
        pair.two              = two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PHASE_FIRST;
            left_reg  <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    b64u_pair_q u_pair_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .pair       (pair),
        .full       (full),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    // a final byte always restarts the group
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_item.final_byte) |=> (phase_reg == PHASE_FIRST && left_reg == 4'd0))
        else $error("group not restarted after final byte");

    // leftover bits at group start are always clear
    a_left_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_FIRST) |-> (left_reg == 4'd0))
        else $error("leftover bits set at group start");

endmodule
